[rtl/cvw_pkg.sv]
// ----------------------------------------------------------------------------
// cvw_pkg
// Shared types, constants and tables for the certificate validity window check.
// ----------------------------------------------------------------------------
package cvw_pkg;

    // pipeline depth: five lane stages plus the merging output stage
    localparam int NUM_STAGES = 6;
    localparam int SECS_W     = 64;

    // result codes
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_BAD_START = 3'd1,
        STATUS_BAD_END   = 3'd2,
        STATUS_NOT_YET   = 3'd3,
        STATUS_EXPIRED   = 3'd4
    } status_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } pipe_ctrl_t;

    // days before the first of each month in a common year
    function automatic logic [8:0] month_start(input logic [3:0] month);
        logic [8:0] res;
        begin
            case (month)
                4'd1:    res = 9'd0;
                4'd2:    res = 9'd31;
                4'd3:    res = 9'd59;
                4'd4:    res = 9'd90;
                4'd5:    res = 9'd120;
                4'd6:    res = 9'd151;
                4'd7:    res = 9'd181;
                4'd8:    res = 9'd212;
                4'd9:    res = 9'd243;
                4'd10:   res = 9'd273;
                4'd11:   res = 9'd304;
                4'd12:   res = 9'd334;
                default: res = 9'd0;
            endcase
            return res;
        end
    endfunction

    // ascii digit test
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // two decimal digits to binary
    function automatic logic [6:0] pair(input logic [3:0] hi, input logic [3:0] lo);
        return ({3'd0, hi} * 7'd10) + {3'd0, lo};
    endfunction

endpackage

[rtl/cvw_lane.sv]
// ----------------------------------------------------------------------------
// cvw_lane
// Converts one packed ASCII certificate time to Unix seconds over five stages.
// ----------------------------------------------------------------------------
module cvw_lane
    import cvw_pkg::*;
(
    input  logic              clk,
    input  pipe_ctrl_t        ctrl,
    input  logic [63:0]       head,
    input  logic [55:0]       tail,
    input  logic [4:0]        len,
    output logic              good,
    output logic [SECS_W-1:0] secs
);

    // reciprocal of 100 scaled by 2^19, exact for the year range used here
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;
    // leap days counted up to year 1969 shifted by 400 years
    localparam logic signed [23:0] LEAPS_EPOCH = 24'sd574;
    localparam logic signed [17:0] DAY_SECS    = 18'sd86400;

    // split characters and test digits
    logic [7:0]  chars [15];
    logic [14:0] dig_ok;
    logic [3:0]  dv [15];
    logic        fmt13;
    logic        fmt15;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            chars[k] = head[63-8*k -: 8];
        end
        for (int k = 0; k < 7; k++)
        begin
            chars[k+8] = tail[55-8*k -: 8];
        end
        for (int k = 0; k < 15; k++)
        begin
            dig_ok[k] = is_digit(chars[k]);
            dv[k]     = chars[k][3:0];
        end
    end

    assign fmt13 = (len == 5'd13);
    assign fmt15 = (len == 5'd15);

    // stage 1: field decode
    logic [6:0]  yy;
    logic [13:0] year13;
    logic [13:0] year15;
    logic [6:0]  month_raw;
    logic        fmt_ok;
    logic        month_ok;

    logic        good1_reg;
    logic [13:0] year1_reg;
    logic [3:0]  month1_reg;
    logic [6:0]  day1_reg;
    logic [6:0]  hour1_reg;
    logic [6:0]  min1_reg;
    logic [6:0]  sec1_reg;

    always_comb
    begin
        yy        = pair(dv[0], dv[1]);
        year13    = {7'd0, yy} + ((yy >= 7'd50) ? 14'd1900 : 14'd2000);
        year15    = ({10'd0, dv[0]} * 14'd1000) + ({10'd0, dv[1]} * 14'd100)
                  + ({10'd0, dv[2]} * 14'd10) + {10'd0, dv[3]};
        month_raw = fmt15 ? pair(dv[4], dv[5]) : pair(dv[2], dv[3]);
        fmt_ok    = (fmt13 && (&dig_ok[11:0])) || (fmt15 && (&dig_ok[13:0]));
        month_ok  = (month_raw >= 7'd1) && (month_raw <= 7'd12);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            good1_reg  <= fmt_ok && month_ok;
            year1_reg  <= fmt15 ? year15 : year13;
            month1_reg <= month_raw[3:0];
            day1_reg   <= fmt15 ? pair(dv[6], dv[7])   : pair(dv[4], dv[5]);
            hour1_reg  <= fmt15 ? pair(dv[8], dv[9])   : pair(dv[6], dv[7]);
            min1_reg   <= fmt15 ? pair(dv[10], dv[11]) : pair(dv[8], dv[9]);
            sec1_reg   <= fmt15 ? pair(dv[12], dv[13]) : pair(dv[10], dv[11]);
        end
    end

    // stage 2: century quotients for the leap count
    logic [13:0] n_shift;
    logic [26:0] n_prod;
    logic [24:0] n4_prod;
    logic [26:0] y_prod;

    logic        good2_reg;
    logic [13:0] year2_reg;
    logic [3:0]  month2_reg;
    logic [6:0]  day2_reg;
    logic [6:0]  hour2_reg;
    logic [6:0]  min2_reg;
    logic [6:0]  sec2_reg;
    logic [11:0] q4n2_reg;
    logic [6:0]  q100n2_reg;
    logic [4:0]  q400n2_reg;
    logic [6:0]  q100y2_reg;

    always_comb
    begin
        n_shift = year1_reg + 14'd399;
        n_prod  = {13'd0, n_shift} * {14'd0, RECIP_100};
        n4_prod = {13'd0, n_shift[13:2]} * {12'd0, RECIP_100};
        y_prod  = {13'd0, year1_reg} * {14'd0, RECIP_100};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[1])
        begin
            good2_reg  <= good1_reg;
            year2_reg  <= year1_reg;
            month2_reg <= month1_reg;
            day2_reg   <= day1_reg;
            hour2_reg  <= hour1_reg;
            min2_reg   <= min1_reg;
            sec2_reg   <= sec1_reg;
            q4n2_reg   <= n_shift[13:2];
            q100n2_reg <= n_prod[RECIP_SH+6:RECIP_SH];
            q400n2_reg <= n4_prod[RECIP_SH+4:RECIP_SH];
            q100y2_reg <= y_prod[RECIP_SH+6:RECIP_SH];
        end
    end

    // stage 3: day count since the epoch
    logic               div100;
    logic               leap;
    logic signed [14:0] yoff;
    logic signed [23:0] yoff_ext;
    logic signed [23:0] days_next;

    logic               good3_reg;
    logic signed [23:0] days3_reg;
    logic [6:0]         hour3_reg;
    logic [6:0]         min3_reg;
    logic [6:0]         sec3_reg;

    always_comb
    begin
        div100    = (year2_reg == ({7'd0, q100y2_reg} * 14'd100));
        leap      = (year2_reg[1:0] == 2'd0) && (!div100 || (q100y2_reg[1:0] == 2'd0));
        yoff      = signed'({1'b0, year2_reg}) - 15'sd1970;
        yoff_ext  = {{9{yoff[14]}}, yoff};
        days_next = (yoff_ext * 24'sd365)
                  + signed'({12'd0, q4n2_reg})
                  - signed'({17'd0, q100n2_reg})
                  + signed'({19'd0, q400n2_reg})
                  - LEAPS_EPOCH
                  + signed'({15'd0, month_start(month2_reg)})
                  + (((month2_reg > 4'd2) && leap) ? 24'sd1 : 24'sd0)
                  + signed'({17'd0, day2_reg})
                  - 24'sd1;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[2])
        begin
            good3_reg <= good2_reg;
            days3_reg <= days_next;
            hour3_reg <= hour2_reg;
            min3_reg  <= min2_reg;
            sec3_reg  <= sec2_reg;
        end
    end

    // stage 4: days to seconds, time of day
    logic               good4_reg;
    logic signed [41:0] prod4_reg;
    logic [18:0]        hms4_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[3])
        begin
            good4_reg <= good3_reg;
            prod4_reg <= 42'(days3_reg) * 42'(DAY_SECS);
            hms4_reg  <= ({12'd0, hour3_reg} * 19'd3600) + ({12'd0, min3_reg} * 19'd60)
                       + {12'd0, sec3_reg};
        end
    end

    // stage 5: final sum, wrapped to 64 bits
    logic              good5_reg;
    logic [SECS_W-1:0] secs5_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[4])
        begin
            good5_reg <= good4_reg;
            secs5_reg <= {{(SECS_W-42){prod4_reg[41]}}, prod4_reg}
                       + {{(SECS_W-19){1'b0}}, hms4_reg};
        end
    end

    assign good = good5_reg;
    assign secs = secs5_reg;

endmodule

[rtl/cvw_merge.sv]
// ----------------------------------------------------------------------------
// cvw_merge
// Aligns the current time with the lanes and forms the registered result.
// ----------------------------------------------------------------------------
module cvw_merge
    import cvw_pkg::*;
(
    input  logic              clk,
    input  pipe_ctrl_t        ctrl,
    input  logic [SECS_W-1:0] now_time,
    input  logic              start_good,
    input  logic [SECS_W-1:0] start_secs,
    input  logic              end_good,
    input  logic [SECS_W-1:0] end_secs,
    output status_t           status,
    output logic [SECS_W-1:0] start_seconds,
    output logic [SECS_W-1:0] end_seconds
);

    localparam int LANE_STAGES = NUM_STAGES - 1;

    // current time delay line matching the lane depth
    logic [SECS_W-1:0] now_reg [LANE_STAGES];

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            now_reg[0] <= now_time;
        end
        for (int k = 1; k < LANE_STAGES; k++)
        begin
            if (ctrl.load[k])
            begin
                now_reg[k] <= now_reg[k-1];
            end
        end
    end

    // window decision
    logic [SECS_W-1:0] now_last;
    status_t           status_next;
    logic [SECS_W-1:0] start_next;
    logic [SECS_W-1:0] end_next;

    assign now_last = now_reg[LANE_STAGES-1];

    always_comb
    begin
        status_next = STATUS_OK;
        start_next  = '0;
        end_next    = '0;
        if (now_last == '0)
        begin
            status_next = STATUS_OK;
        end
        else if (!start_good)
        begin
            status_next = STATUS_BAD_START;
        end
        else if (!end_good)
        begin
            status_next = STATUS_BAD_END;
            start_next  = start_secs;
        end
        else
        begin
            start_next = start_secs;
            end_next   = end_secs;
            if (now_last < start_secs)
            begin
                status_next = STATUS_NOT_YET;
            end
            else if (now_last > end_secs)
            begin
                status_next = STATUS_EXPIRED;
            end
            else
            begin
                status_next = STATUS_OK;
            end
        end
    end

    // output register
    status_t           status_reg;
    logic [SECS_W-1:0] start_reg;
    logic [SECS_W-1:0] end_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load[NUM_STAGES-1])
        begin
            status_reg <= status_next;
            start_reg  <= start_next;
            end_reg    <= end_next;
        end
    end

    assign status        = status_reg;
    assign start_seconds = start_reg;
    assign end_seconds   = end_reg;

endmodule

[rtl/certificate_validity_window_check_unit.sv]
// Five lane stages and one output stage lie between item accept and result valid.
// Throughput: one item per cycle; each stage advances when it is empty or the next one moves,
// so a held result at the output does not stop items filling the empty stages behind it.
// Reset clears only the stage valid bits; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// certificate_validity_window_check_unit
// Converts not-before and not-after time strings in two parallel lanes and
// checks the current Unix time against the resulting window.
// ----------------------------------------------------------------------------
module certificate_validity_window_check_unit
    import cvw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] now_time,
    input  logic [63:0] before_head,
    input  logic [55:0] before_tail,
    input  logic [4:0]  before_len,
    input  logic [63:0] after_head,
    input  logic [55:0] after_tail,
    input  logic [4:0]  after_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [63:0] start_seconds,
    output logic [63:0] end_seconds
);

    // stage valid bits and per-stage advance
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   adv;
    pipe_ctrl_t            ctrl;

    always_comb
    begin
        adv[NUM_STAGES] = out_ready;
        for (int k = NUM_STAGES - 1; k >= 0; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k+1];
        end
        valid_next[0] = adv[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = adv[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load = adv[NUM_STAGES-1:0];
    assign in_ready  = adv[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // not-before lane
    logic              start_good;
    logic [SECS_W-1:0] start_secs;

    cvw_lane u_lane_start
    (
        .clk  (clk),
        .ctrl (ctrl),
        .head (before_head),
        .tail (before_tail),
        .len  (before_len),
        .good (start_good),
        .secs (start_secs)
    );

    // not-after lane
    logic              end_good;
    logic [SECS_W-1:0] end_secs;

    cvw_lane u_lane_end
    (
        .clk  (clk),
        .ctrl (ctrl),
        .head (after_head),
        .tail (after_tail),
        .len  (after_len),
        .good (end_good),
        .secs (end_secs)
    );

    // window check and output register
    status_t status_q;

    cvw_merge u_merge
    (
        .clk           (clk),
        .ctrl          (ctrl),
        .now_time      (now_time),
        .start_good    (start_good),
        .start_secs    (start_secs),
        .end_good      (end_good),
        .end_secs      (end_secs),
        .status        (status_q),
        .start_seconds (start_seconds),
        .end_seconds   (end_seconds)
    );

    assign status = status_q;

    // an accepted item occupies the first stage on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted item did not enter the first stage");

    // a malformed not-before reports no seconds at all
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_BAD_START) |-> (start_seconds == '0) && (end_seconds == '0))
        else $error("bad not-before item carries seconds");

    // a malformed not-after reports no end seconds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_BAD_END) |-> (end_seconds == '0))
        else $error("bad not-after item carries end seconds");

    // a passing window is never inverted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STATUS_OK) |-> (start_seconds <= end_seconds))
        else $error("valid item with start after end");

endmodule

[dv/validity_verdict_checker.sv]
// ----------------------------------------------------------------------------
// validity_verdict_checker
// Watches both channels of the certificate validity window check, predicts the
// verdict and the window seconds for every accepted item and compares them,
// field by field and in order, with the results that the block delivers.
// ----------------------------------------------------------------------------
module validity_verdict_checker
    import cvw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] now_time,
    input  logic [63:0] before_head,
    input  logic [55:0] before_tail,
    input  logic [4:0]  before_len,
    input  logic [63:0] after_head,
    input  logic [55:0] after_tail,
    input  logic [4:0]  after_len,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  status,
    input  logic [63:0] start_seconds,
    input  logic [63:0] end_seconds,
    output int          failures,
    output int          outstanding,
    output logic [63:0] last_window_start,
    output logic [63:0] last_window_end
);

    typedef struct packed {
        status_t     code;
        logic [63:0] start_s;
        logic [63:0] end_s;
    } verdict_t;

    verdict_t    verdict_queue [$];
    verdict_t    due;
    int          fault_tally;
    int          mismatch_count = 0;
    int          pending_count  = 0;
    logic [63:0] window_start_q = '0;
    logic [63:0] window_end_q   = '0;

    assign failures          = mismatch_count;
    assign outstanding       = pending_count;
    assign last_window_start = window_start_q;
    assign last_window_end   = window_end_q;

    // leap years in 1..n, n positive
    function automatic longint leaps_through(input longint n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    // time string to unix seconds mod 2^64, returns 0 when malformed
    function automatic logic time_to_unix(input logic [63:0] head, input logic [55:0] tail,
                                          input logic [4:0] len, output logic [63:0] secs);
        int         k;
        int         used;
        int         ofs;
        int         dig [14];
        logic [7:0] ch;
        longint     yr;
        longint     mon;
        longint     dy;
        longint     hr;
        longint     mn;
        longint     sc;
        longint     days;
        longint     mstart;
        secs = '0;
        if (len == 5'd13)
        begin
            used = 12;
            ofs  = 2;
        end
        else if (len == 5'd15)
        begin
            used = 14;
            ofs  = 4;
        end
        else
            return 1'b0;

        // every used character must be a decimal digit
        for (k = 0; k < used; k++)
        begin
            if (k < 8)
                ch = head[63 - 8 * k -: 8];
            else
                ch = tail[55 - 8 * (k - 8) -: 8];
            if (ch < 8'h30 || ch > 8'h39)
                return 1'b0;
            dig[k] = ch - 8'h30;
        end

        // two-digit years pivot at 50
        if (ofs == 2)
        begin
            yr = dig[0] * 10 + dig[1];
            yr = yr + ((yr >= 50) ? 1900 : 2000);
        end
        else
            yr = dig[0] * 1000 + dig[1] * 100 + dig[2] * 10 + dig[3];
        mon = dig[ofs] * 10 + dig[ofs + 1];
        dy  = dig[ofs + 2] * 10 + dig[ofs + 3];
        hr  = dig[ofs + 4] * 10 + dig[ofs + 5];
        mn  = dig[ofs + 6] * 10 + dig[ofs + 7];
        sc  = dig[ofs + 8] * 10 + dig[ofs + 9];
        if (mon < 1 || mon > 12)
            return 1'b0;

        case (mon)
            1:       mstart = 0;
            2:       mstart = 31;
            3:       mstart = 59;
            4:       mstart = 90;
            5:       mstart = 120;
            6:       mstart = 151;
            7:       mstart = 181;
            8:       mstart = 212;
            9:       mstart = 243;
            10:      mstart = 273;
            11:      mstart = 304;
            default: mstart = 334;
        endcase

        // day count from the epoch, 400-year shift keeps the leap count exact
        days = 365 * (yr - 1970) + leaps_through(yr + 399) - leaps_through(2369);
        days = days + mstart;
        if (mon > 2 && ((yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0))
            days = days + 1;
        days = days + dy - 1;

        // two's complement wrap gives the modulo 2^64 result
        secs = days * 86400 + hr * 3600 + mn * 60 + sc;
        return 1'b1;
    endfunction

    function automatic verdict_t predict_verdict(input logic [63:0] now,
                                                 input logic [63:0] b_head,
                                                 input logic [55:0] b_tail,
                                                 input logic [4:0]  b_len,
                                                 input logic [63:0] a_head,
                                                 input logic [55:0] a_tail,
                                                 input logic [4:0]  a_len);
        verdict_t    v;
        logic [63:0] nb;
        logic [63:0] na;
        v.code    = STATUS_OK;
        v.start_s = '0;
        v.end_s   = '0;
        // no clock: check skipped
        if (now == 64'd0)
            return v;
        if (!time_to_unix(b_head, b_tail, b_len, nb))
        begin
            v.code = STATUS_BAD_START;
            return v;
        end
        v.start_s = nb;
        if (!time_to_unix(a_head, a_tail, a_len, na))
        begin
            v.code = STATUS_BAD_END;
            return v;
        end
        v.end_s = na;
        if (now < nb)
            v.code = STATUS_NOT_YET;
        else if (now > na)
            v.code = STATUS_EXPIRED;
        return v;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            fault_tally = mismatch_count;

            // delivered result against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d start %0h end %0h",
                           status, start_seconds, end_seconds);
                    fault_tally++;
                end
                else
                begin
                    due = verdict_queue.pop_front();
                    if (status !== due.code)
                    begin
                        $error("status mismatch: expected %0d, got %0d", due.code, status);
                        fault_tally++;
                    end
                    if (start_seconds !== due.start_s)
                    begin
                        $error("start_seconds mismatch: expected %0h, got %0h",
                               due.start_s, start_seconds);
                        fault_tally++;
                    end
                    if (end_seconds !== due.end_s)
                    begin
                        $error("end_seconds mismatch: expected %0h, got %0h",
                               due.end_s, end_seconds);
                        fault_tally++;
                    end
                end
            end

            // accepted item: predict and queue
            if (in_valid && in_ready)
            begin
                due = predict_verdict(now_time, before_head, before_tail, before_len,
                                      after_head, after_tail, after_len);
                verdict_queue.push_back(due);
                window_start_q <= due.start_s;
                window_end_q   <= due.end_s;
            end

            mismatch_count <= fault_tally;
            pending_count  <= verdict_queue.size();
        end
    end

endmodule

[dv/certificate_validity_window_check_unit_test.sv]
// ----------------------------------------------------------------------------
// certificate_validity_window_check_unit_test
// Drives time-string pairs and current times into the validity window check:
// a directed set of corner cases, then random well-formed and broken stamps
// under three idle patterns, with the window checker beside the block.
// ----------------------------------------------------------------------------
module certificate_validity_window_check_unit_test;
    import cvw_pkg::*;

    typedef struct packed {
        logic [63:0] now;
        logic [63:0] b_head;
        logic [55:0] b_tail;
        logic [4:0]  b_len;
        logic [63:0] a_head;
        logic [55:0] a_tail;
        logic [4:0]  a_len;
    } check_item_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [63:0] now_time    = '0;
    logic [63:0] before_head = '0;
    logic [55:0] before_tail = '0;
    logic [4:0]  before_len  = '0;
    logic [63:0] after_head  = '0;
    logic [55:0] after_tail  = '0;
    logic [4:0]  after_len   = '0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [2:0]  status;
    logic [63:0] start_seconds;
    logic [63:0] end_seconds;

    int          failures;
    int          outstanding;
    logic [63:0] window_lo;
    logic [63:0] window_hi;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          sent        = 0;

    certificate_validity_window_check_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_time      (now_time),
        .before_head   (before_head),
        .before_tail   (before_tail),
        .before_len    (before_len),
        .after_head    (after_head),
        .after_tail    (after_tail),
        .after_len     (after_len),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .start_seconds (start_seconds),
        .end_seconds   (end_seconds)
    );

    validity_verdict_checker verdict_chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .now_time          (now_time),
        .before_head       (before_head),
        .before_tail       (before_tail),
        .before_len        (before_len),
        .after_head        (after_head),
        .after_tail        (after_tail),
        .after_len         (after_len),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .start_seconds     (start_seconds),
        .end_seconds       (end_seconds),
        .failures          (failures),
        .outstanding       (outstanding),
        .last_window_start (window_lo),
        .last_window_end   (window_hi)
    );

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // pack a stamp: Z after the counted characters, junk beyond
    function automatic void encode_stamp(input string s, output logic [63:0] head,
                                         output logic [55:0] tail, output logic [4:0] len);
        logic [119:0] text;
        int           k;
        for (k = 0; k < 15; k++)
        begin
            if (k < s.len())
                text[119 - 8 * k -: 8] = s[k];
            else if (k == s.len())
                text[119 - 8 * k -: 8] = "Z";
            else
                text[119 - 8 * k -: 8] = 8'($urandom_range(255));
        end
        head = text[119:56];
        tail = text[55:0];
        len  = (s.len() > 16) ? 5'd16 : 5'(s.len());
    endfunction

    function automatic check_item_t text_item(input logic [63:0] now, input string nb,
                                              input string na);
        check_item_t it;
        it.now = now;
        encode_stamp(nb, it.b_head, it.b_tail, it.b_len);
        encode_stamp(na, it.a_head, it.a_tail, it.a_len);
        return it;
    endfunction

    // mostly plausible dates, some out-of-range fields and stray non-digits
    function automatic string random_stamp();
        string       s;
        logic [7:0]  ch;
        int unsigned yr;
        int unsigned mon;
        int unsigned dy;
        int unsigned hr;
        int unsigned mn;
        int unsigned sc;
        if ($urandom_range(1))
            s = $sformatf("%02d", $urandom_range(99));
        else
        begin
            yr = ($urandom_range(9) < 7) ? $urandom_range(2100, 1900) : $urandom_range(9999);
            s  = $sformatf("%04d", yr);
        end
        mon = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
        dy  = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(28, 1);
        hr  = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(23);
        mn  = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
        sc  = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(59);
        s   = {s, $sformatf("%02d%02d%02d%02d%02d", mon, dy, hr, mn, sc), "0"};

        // trailing character is counted but never examined
        if ($urandom_range(1))
            s.putc(s.len() - 1, 8'($urandom_range(255, 1)));
        else
            s.putc(s.len() - 1, 8'(8'h30 + $urandom_range(9)));

        // stray non-digit in a used position
        if ($urandom_range(9) == 0)
        begin
            do
                ch = 8'($urandom_range(255, 1));
            while (ch >= 8'h30 && ch <= 8'h39);
            s.putc($urandom_range(s.len() - 2), ch);
        end
        return s;
    endfunction

    // one side of an item, sometimes with a wrong length or pure noise
    function automatic void random_side(output logic [63:0] head, output logic [55:0] tail,
                                        output logic [4:0] len);
        int unsigned pick;
        encode_stamp(random_stamp(), head, tail, len);
        pick = $urandom_range(99);
        if (pick < 6)
            len = 5'($urandom_range(16));
        else if (pick < 9)
        begin
            head = {$urandom, $urandom};
            tail = 56'({$urandom, $urandom});
            len  = 5'($urandom_range(16));
        end
    endfunction

    function automatic check_item_t random_item();
        check_item_t it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            it.now = '0;
        else if (pick < 20)
            it.now = {$urandom, $urandom};
        else if (pick < 50)
            it.now = {32'd0, 32'($urandom)};
        else
            it.now = {26'd0, 6'($urandom_range(63)), 32'($urandom)};
        random_side(it.b_head, it.b_tail, it.b_len);
        random_side(it.a_head, it.a_tail, it.a_len);
        return it;
    endfunction

    // present one item after a random gap and hold it until accepted
    task automatic offer(input check_item_t it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        now_time    <= it.now;
        before_head <= it.b_head;
        before_tail <= it.b_tail;
        before_len  <= it.b_len;
        after_head  <= it.a_head;
        after_tail  <= it.a_tail;
        after_len   <= it.a_len;
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
    endtask

    // learn the window of a stamp pair, then put now on and around its bounds
    task automatic probe_edges(input check_item_t it);
        logic [63:0] marks [6];
        int          k;
        it.now = 64'd1;
        offer(it);
        in_valid <= 1'b0;
        @(posedge clk);
        marks[0] = window_lo - 64'd1;
        marks[1] = window_lo;
        marks[2] = window_lo + 64'd1;
        marks[3] = window_hi - 64'd1;
        marks[4] = window_hi;
        marks[5] = window_hi + 64'd1;
        for (k = 0; k < 6; k++)
        begin
            it.now = marks[k];
            offer(it);
        end
    endtask

    // stop sending until every outstanding result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    task automatic random_phase(input int count);
        int goal;
        goal = sent + count;
        while (sent < goal)
        begin
            if ($urandom_range(99) < 5)
                probe_edges(random_item());
            else
                offer(random_item());
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n       <= 1'b1;
        tx_idle_pct = 12;
        rx_idle_pct <= 47;
        @(posedge clk);

        // no clock: skipped whatever the stamps hold
        offer(text_item(64'd0, "491231235959x", "500101000000x"));
        offer(text_item(64'd0, "bad", ""));
        // largest now against the far end of the four-digit range
        offer(text_item(64'hFFFF_FFFF_FFFF_FFFF, "197001010000000", "99991231235959x"));

        // lengths other than 13 or 15
        offer(text_item(64'd1_700_000_000, "491231235959", "491231235959x"));
        offer(text_item(64'd1_700_000_000, "19700101000000", "491231235959x"));
        offer(text_item(64'd1_700_000_000, "1970010100000000", "491231235959x"));
        offer(text_item(64'd1_700_000_000, "", "491231235959x"));

        // non-digits in used positions, both sides of the digit range
        offer(text_item(64'd1_700_000_000, "A91231235959x", "491231235959x"));
        offer(text_item(64'd1_700_000_000, "49123123595:x", "491231235959x"));
        offer(text_item(64'd1_700_000_000, "4912/1235959x", "491231235959x"));

        // month zero and thirteen
        offer(text_item(64'd1_700_000_000, "490012000000x", "491231235959x"));
        offer(text_item(64'd1_700_000_000, "491301000000x", "491231235959x"));

        // bad not-after keeps the not-before seconds
        offer(text_item(64'd1_700_000_000, "200101000000x", "251301000000x"));
        offer(text_item(64'd1_700_000_000, "200101000000x", "20250101000000"));

        // two-digit year pivot, year zero, leap and non-leap centuries
        offer(text_item(64'd1_000_000_000, "500101000000x", "491231235959x"));
        offer(text_item(64'd1, "00000101000000x", "99991231235959x"));
        offer(text_item(64'd951_868_800, "16000229000000x", "20000301000000x"));
        offer(text_item(64'd951_868_800, "19000301000000x", "20240229235959x"));

        // day zero with oversized hour, minute and second
        offer(text_item(64'd1_709_251_200, "20240300999999x", "20240301000000x"));

        // now on and around both bounds
        probe_edges(text_item(64'd1, "230101000000x", "251231235959x"));

        random_phase(170);
        drain_results();

        tx_idle_pct = 47;
        rx_idle_pct <= 12;
        random_phase(170);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        random_phase(170);
        drain_results();

        // room for any stray result
        repeat (NUM_STAGES * 4) @(posedge clk);
        if (failures == 0)
            $display("certificate_validity_window_check_unit verification clean");
        else
            $display("certificate_validity_window_check_unit verification failed");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("certificate_validity_window_check_unit verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/cvw_pkg.sv
rtl/cvw_lane.sv
rtl/cvw_merge.sv
rtl/certificate_validity_window_check_unit.sv
dv/validity_verdict_checker.sv
dv/certificate_validity_window_check_unit_test.sv
